/* hdl/gas_source_switchover_alarm_macros.svh */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GAS_SOURCE_SWITCHOVER_ALARM_MACROS_SVH
`define GAS_SOURCE_SWITCHOVER_ALARM_MACROS_SVH

// same-cycle implication
`define GSSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gssa assertion failed");

// next-cycle implication
`define GSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gssa assertion failed");

`endif

/* hdl/gssa_pkg.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - package
// Types, codes and constants shared by the block's files.
// ----------------------------------------------------------------------------
`default_nettype none

package gssa_pkg;

	localparam int PRESS_STEP             = 100;
	localparam int SUPPLY_HIGH            = 3500;
	localparam int SUPPLY_LOW             = 2500;
	localparam int BATTERY_LOW            = 2000;
	localparam int BATTERY_OK             = 2400;
	localparam int CONC_LOST_BEEP_SECONDS = 5;
	localparam int LED_MAX                = 20;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONC_HIGH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CONC_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RETURN_DLY  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SWITCH = 3'd7;

	localparam logic [1:0] SRC_LEFT   = 2'd0;
	localparam logic [1:0] SRC_RIGHT  = 2'd1;
	localparam logic [1:0] SRC_CONC   = 2'd2;
	localparam logic [1:0] SRC_UNUSED = 2'd3;

	localparam int AL_EMPTY     = 0;
	localparam int AL_LINE_HIGH = 1;
	localparam int AL_LINE_LOW  = 2;
	localparam int AL_CONC_HIGH = 3;
	localparam int AL_CONC_BAD  = 4;
	localparam int AL_POWER     = 5;
	localparam int AL_BATTERY   = 6;

	localparam int DSP_RIGHT_LOW = 0;
	localparam int DSP_LEFT_LOW  = 1;
	localparam int DSP_CONC_OOR  = 2;
	localparam int DSP_LINE_OOR  = 3;

	localparam logic [6:0] ALARM_RESET = 7'(1 << AL_CONC_BAD);

	typedef struct packed {
		logic [11:0] press_left;
		logic [11:0] press_right;
		logic [11:0] press_line;
		logic [11:0] press_conc;
		logic [11:0] supply_volts;
		logic [11:0] battery_volts;
		logic        swap_request;
		logic        requested_side;
		logic        second_tick;
	} in_item_t;

	typedef struct packed {
		logic [4:0] led_left;
		logic [4:0] led_right;
		logic       left_valve_pin;
		logic       right_valve_pin;
		logic [1:0] active_source;
		logic [6:0] alarm_flags;
		logic [3:0] display_flags;
		logic       buzzer_on;
	} out_item_t;

	typedef struct packed {
		logic [11:0] switch_threshold;
		logic [11:0] empty_threshold;
		logic [11:0] line_high_limit;
		logic [11:0] line_low_limit;
		logic [11:0] conc_high_limit;
		logic [11:0] conc_low_limit;
		logic [7:0]  conc_return_delay;
		logic        auto_switch_always;
	} cfg_t;

	typedef struct packed {
		logic [1:0] source;
		logic       last_cylinder;
		logic       conc_was_ok;
		logic [7:0] conc_wait_count;
		logic [7:0] conc_lost_beep_count;
		logic       blink;
		logic [6:0] alarm_state;
	} state_t;

	// 1 + p / PRESS_STEP, saturating at LED_MAX
	function automatic logic [4:0] bar_level(input logic [11:0] p);
		logic [4:0] lvl;
		lvl = 5'd1;
		for (int k = 1; k < LED_MAX; k++) begin
			if (int'(p) >= k * PRESS_STEP)
				lvl = 5'(k + 1);
		end
		return lvl;
	endfunction

endpackage

`default_nettype wire

/* hdl/gssa_in_if.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - sample channel
// Valid/ready channel carrying one sensor sample set per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gssa_in_if
	import gssa_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/gssa_out_if.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gssa_out_if
	import gssa_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/gssa_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - configuration registers
// Write-only register file for thresholds, limits and switch options.
// ----------------------------------------------------------------------------
`default_nettype none

module gssa_cfg_regs
	import gssa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_threshold   <= 12'd0;
			cfg_q.empty_threshold    <= 12'd0;
			cfg_q.line_high_limit    <= 12'd4095;
			cfg_q.line_low_limit     <= 12'd0;
			cfg_q.conc_high_limit    <= 12'd4095;
			cfg_q.conc_low_limit     <= 12'd0;
			cfg_q.conc_return_delay  <= 8'd0;
			cfg_q.auto_switch_always <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SWITCH_THR:  cfg_q.switch_threshold   <= cfg_wdata;
				CFG_EMPTY_THR:   cfg_q.empty_threshold    <= cfg_wdata;
				CFG_LINE_HIGH:   cfg_q.line_high_limit    <= cfg_wdata;
				CFG_LINE_LOW:    cfg_q.line_low_limit     <= cfg_wdata;
				CFG_CONC_HIGH:   cfg_q.conc_high_limit    <= cfg_wdata;
				CFG_CONC_LOW:    cfg_q.conc_low_limit     <= cfg_wdata;
				CFG_RETURN_DLY:  cfg_q.conc_return_delay  <= cfg_wdata[7:0];
				CFG_AUTO_SWITCH: cfg_q.auto_switch_always <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hdl/gssa_step.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - step logic
// Source selection, valve pins, alarms, display flags and buzzer for one
// sample, plus the next controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module gssa_step
	import gssa_pkg::*;
(
	input  cfg_t      cfg,
	input  state_t    state,
	input  in_item_t  item,
	output state_t    state_nxt,
	output out_item_t res
);

	always_comb begin
		logic [1:0]  src;
		logic        last_cyl;
		logic        was_ok;
		logic [7:0]  wait_cnt;
		logic [7:0]  beep_cnt;
		logic        pin_l;
		logic        pin_r;
		logic [11:0] own;
		logic [11:0] other;
		logic [6:0]  al;
		logic [3:0]  disp;
		logic        buzz;
		logic [11:0] pl;
		logic [11:0] pr;
		logic [11:0] sw;

		pl       = item.press_left;
		pr       = item.press_right;
		sw       = cfg.switch_threshold;
		src      = state.source;
		last_cyl = state.last_cylinder;
		was_ok   = state.conc_was_ok;
		wait_cnt = state.conc_wait_count;
		beep_cnt = state.conc_lost_beep_count;
		pin_l    = 1'b1;
		pin_r    = 1'b1;

		if (item.swap_request && pr >= sw && pl >= sw && src != SRC_CONC)
			src = {1'b0, item.requested_side};

		own   = (src == SRC_LEFT) ? pl : pr;
		other = (src == SRC_LEFT) ? pr : pl;

		case (src)
			SRC_LEFT, SRC_RIGHT: begin
				if (src == SRC_LEFT)
					pin_l = 1'b0;
				else
					pin_r = 1'b0;
				if (own <= sw && (cfg.auto_switch_always || state.alarm_state[AL_LINE_LOW])
					&& other >= sw) begin
					last_cyl = ~src[0];
					src      = {1'b0, ~src[0]};
				end
				if (!was_ok && !state.alarm_state[AL_CONC_BAD]) begin
					wait_cnt = cfg.conc_return_delay;
					was_ok   = 1'b1;
				end
				if (was_ok && wait_cnt == 8'd0)
					src = SRC_CONC;
			end
			SRC_CONC: begin
				if (state.alarm_state[AL_CONC_BAD]) begin
					beep_cnt = 8'(CONC_LOST_BEEP_SECONDS);
					src      = {1'b0, last_cyl};
					was_ok   = 1'b0;
				end
			end
			default: ;
		endcase

		al = 7'd0;
		al[AL_EMPTY]     = (pl <= sw && pr <= cfg.empty_threshold)
			|| (pr <= sw && pl <= cfg.empty_threshold);
		al[AL_LINE_HIGH] = item.press_line > cfg.line_high_limit;
		al[AL_LINE_LOW]  = item.press_line < cfg.line_low_limit;
		al[AL_CONC_HIGH] = item.press_conc > cfg.conc_high_limit;
		al[AL_CONC_BAD]  = item.press_conc < cfg.conc_low_limit;
		al[AL_POWER]     = item.supply_volts > 12'(SUPPLY_HIGH)
			|| item.supply_volts < 12'(SUPPLY_LOW);
		if (item.battery_volts < 12'(BATTERY_LOW) && item.supply_volts < 12'(SUPPLY_LOW))
			al[AL_BATTERY] = 1'b1;
		else if (item.battery_volts <= 12'(BATTERY_OK))
			al[AL_BATTERY] = state.alarm_state[AL_BATTERY];

		disp = 4'd0;
		disp[DSP_RIGHT_LOW] = pr < cfg.empty_threshold;
		disp[DSP_LEFT_LOW]  = pl < cfg.empty_threshold;
		disp[DSP_CONC_OOR]  = al[AL_CONC_HIGH] || al[AL_CONC_BAD];
		disp[DSP_LINE_OOR]  = al[AL_LINE_HIGH] || al[AL_LINE_LOW];

		if (al[AL_BATTERY])
			buzz = 1'b1;
		else if (al[AL_CONC_HIGH] || al[AL_EMPTY] || al[AL_LINE_HIGH] || al[AL_LINE_LOW])
			buzz = 1'b1;
		else if (al[AL_POWER])
			buzz = (beep_cnt != 8'd0) || state.blink;
		else
			buzz = beep_cnt != 8'd0;

		state_nxt.source               = src;
		state_nxt.last_cylinder        = last_cyl;
		state_nxt.conc_was_ok          = was_ok;
		state_nxt.alarm_state          = al;
		state_nxt.blink                = state.blink ^ item.second_tick;
		state_nxt.conc_wait_count      = (item.second_tick && wait_cnt != 8'd0)
			? wait_cnt - 8'd1 : wait_cnt;
		state_nxt.conc_lost_beep_count = (item.second_tick && beep_cnt != 8'd0)
			? beep_cnt - 8'd1 : beep_cnt;

		res.led_left        = bar_level(pl);
		res.led_right       = bar_level(pr);
		res.left_valve_pin  = pin_l;
		res.right_valve_pin = pin_r;
		res.active_source   = src;
		res.alarm_flags     = al;
		res.display_flags   = disp;
		res.buzzer_on       = buzz;
	end

endmodule

`default_nettype wire

/* hdl/gas_source_switchover_alarm.sv */
// ----------------------------------------------------------------------------
// Gas source switchover alarm - top level
// Picks the gas source per sensor sample and reports valves, bars, alarms.
// ----------------------------------------------------------------------------
// One request on the sample channel gives one request on the result channel.
// A sample is registered in the input stage, evaluated against the controller
// state by combinational compare logic, and its result lands in an output
// register; a new sample is taken every cycle while the result channel does
// not stall, with the controller state updated as each result is registered.
// The output register holds a result while the result channel stalls.
// Configuration writes take effect at the next edge and belong in idle time.
`default_nettype none

module gas_source_switchover_alarm
	import gssa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	gssa_in_if.sink                    sample,
	gssa_out_if.source                 result,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	`include "gas_source_switchover_alarm_macros.svh"

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	state_t    state_q;
	state_t    state_nxt;
	out_item_t res_nxt;
	out_item_t res_q;
	logic      res_valid_q;
	logic      out_free;
	logic      advance;

	gssa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gssa_step u_step (
		.cfg       (cfg),
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.res       (res_nxt)
	);

	assign out_free     = !res_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid)
			item_s1 <= sample.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.source               <= SRC_LEFT;
			state_q.last_cylinder        <= 1'b0;
			state_q.conc_was_ok          <= 1'b0;
			state_q.conc_wait_count      <= 8'd0;
			state_q.conc_lost_beep_count <= 8'd0;
			state_q.blink                <= 1'b0;
			state_q.alarm_state          <= ALARM_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	`GSSA_ASSERT_NOW(a_src_code, clk, arst_n, 1'b1, state_q.source != SRC_UNUSED)
	`GSSA_ASSERT_NOW(a_conc_ok, clk, arst_n, state_q.source == SRC_CONC, state_q.conc_was_ok)
	`GSSA_ASSERT_NOW(a_one_valve, clk, arst_n, result.valid,
		result.data.left_valve_pin || result.data.right_valve_pin)
	`GSSA_ASSERT_NEXT(a_state_hold, clk, arst_n, !advance, $stable(state_q))

endmodule

`default_nettype wire
